[rtl/core/bppd_pkg.sv]
// ----------------------------------------------------------------------------
// bppd_pkg
// Shared types and constants for the button press pattern decoder.
// ----------------------------------------------------------------------------
package bppd_pkg;

  localparam int NumButtons = 3;
  localparam int CodeBits   = 2;
  localparam int PatternW   = 8;
  localparam int CntW       = 16;
  localparam int IdxW       = 2;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 16;

  localparam int InTdataW   = ((NumButtons + 7) / 8) * 8;
  localparam int OutFieldW  = IdxW + PatternW;
  localparam int OutTdataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // press code: top bit marks a valid press, bit 0 marks a long one
  localparam logic [CodeBits-1:0] CodeValid = CodeBits'(2);
  localparam logic [CodeBits-1:0] CodeLong  = CodeBits'(1);

  typedef enum logic [CfgAddrW-1:0] {
    REG_GLITCH_TICKS = 2'd0,
    REG_SHORT_TICKS  = 2'd1,
    REG_GAP_TIMEOUT  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  localparam logic [CntW-1:0] GlitchReset  = CntW'(20);
  localparam logic [CntW-1:0] ShortReset   = CntW'(500);
  localparam logic [CntW-1:0] TimeoutReset = CntW'(400);

  typedef struct packed {
    logic [CntW-1:0] glitch_ticks;
    logic [CntW-1:0] short_ticks;
    logic [CntW-1:0] gap_timeout_ticks;
  } cfg_t;

  // set of finished patterns produced by one tick
  typedef struct packed {
    logic [NumButtons-1:0]               mask;
    logic [NumButtons-1:0][PatternW-1:0] pattern;
  } batch_t;

endpackage

[rtl/core/button_press_pattern_decoder_core.sv]
// ----------------------------------------------------------------------------
// button_press_pattern_decoder_core
// Multi-click pattern decoder: one tick of button levels per transaction,
// emits finished button patterns when their gap timeout runs out.
// ----------------------------------------------------------------------------
// Latency: a tick's results appear the cycle after its transaction.
// Throughput: one tick per cycle while each tick finishes at most one button
// and the output is ready; a tick finishing more than one button holds the input
// while the result register sends them out one per cycle, and an
// output stall holds the input until the pending results are taken.
// Reset: asynchronous, active low; clears all button state and restores the
// register defaults (glitch 20, short 500, gap timeout 400).
module button_press_pattern_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bppd_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [bppd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bppd_pkg::InTdataW-1:0]      s_axis_tdata_i,  // [2:0] levels
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [bppd_pkg::OutTdataW-1:0]     m_axis_tdata_o,  // [1:0] button_index, [9:2] pattern
  output logic                               m_axis_tlast_o
);

  bppd_pkg::cfg_t   cfg_q;
  bppd_pkg::batch_t batch;
  logic             accept;
  logic             can_load;
  logic [bppd_pkg::NumButtons-1:0] levels;
  logic [bppd_pkg::NumButtons-1:0] fire;
  logic [bppd_pkg::NumButtons-1:0][bppd_pkg::PatternW-1:0] btn_pat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_ticks      <= bppd_pkg::GlitchReset;
      cfg_q.short_ticks       <= bppd_pkg::ShortReset;
      cfg_q.gap_timeout_ticks <= bppd_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (bppd_pkg::cfg_reg_e'(cfg_addr_i))
        bppd_pkg::REG_GLITCH_TICKS: cfg_q.glitch_ticks      <= cfg_wdata_i;
        bppd_pkg::REG_SHORT_TICKS:  cfg_q.short_ticks       <= cfg_wdata_i;
        bppd_pkg::REG_GAP_TIMEOUT:  cfg_q.gap_timeout_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = can_load;
  assign accept          = s_axis_tvalid_i && can_load;
  assign levels          = s_axis_tdata_i[bppd_pkg::NumButtons-1:0];

  for (genvar b = 0; b < bppd_pkg::NumButtons; b++) begin : g_btn
    bppd_btn u_btn (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (cfg_q),
      .tick_i    (accept),
      .level_i   (levels[b]),
      .fire_o    (fire[b]),
      .pattern_o (btn_pat[b])
    );
  end

  assign batch = {fire, btn_pat};

  bppd_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept && (batch.mask != '0)),
    .batch_i         (batch),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[rtl/core/bppd_btn.sv]
// ----------------------------------------------------------------------------
// bppd_btn
// Per-button tracker: press timing, pattern shift register, gap timeout.
// ----------------------------------------------------------------------------
module bppd_btn (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bppd_pkg::cfg_t                  cfg_i,
  input  logic                            tick_i,
  input  logic                            level_i,
  output logic                            fire_o,
  output logic [bppd_pkg::PatternW-1:0]   pattern_o
);

  logic                          pressed_q, pressed_d;
  logic                          armed_q, armed_d;
  logic [bppd_pkg::CntW-1:0]     press_len_q, press_len_d;
  logic [bppd_pkg::CntW-1:0]     gap_cnt_q, gap_cnt_d;
  logic [bppd_pkg::PatternW-1:0] pattern_q, pattern_d;

  logic [bppd_pkg::CntW-1:0]     press_len_inc;
  logic [bppd_pkg::CntW-1:0]     gap_cnt_inc;
  logic [bppd_pkg::CodeBits-1:0] code;
  logic                          fire;

  assign press_len_inc = (press_len_q == bppd_pkg::CntMax) ? press_len_q
                                                           : press_len_q + 1'b1;
  assign gap_cnt_inc   = (gap_cnt_q == bppd_pkg::CntMax) ? gap_cnt_q
                                                         : gap_cnt_q + 1'b1;

  assign code = (press_len_q < cfg_i.short_ticks) ? bppd_pkg::CodeValid
              : (bppd_pkg::CodeValid | bppd_pkg::CodeLong);

  // timeout expires on an idle tick; a zero timeout acts as one
  assign fire = !pressed_q && !level_i && armed_q &&
                (gap_cnt_inc >= cfg_i.gap_timeout_ticks);

  assign fire_o    = fire;
  assign pattern_o = pattern_q;

  always_comb begin
    pressed_d   = pressed_q;
    armed_d     = armed_q;
    press_len_d = press_len_q;
    gap_cnt_d   = gap_cnt_q;
    pattern_d   = pattern_q;
    if (tick_i) begin
      if (!pressed_q && level_i) begin
        pressed_d   = 1'b1;
        press_len_d = bppd_pkg::CntW'(1);
        armed_d     = 1'b0;
        gap_cnt_d   = '0;
      end else if (pressed_q && !level_i) begin
        pressed_d   = 1'b0;
        press_len_d = '0;
        if (press_len_q > cfg_i.glitch_ticks) begin
          pattern_d = {pattern_q[bppd_pkg::PatternW-bppd_pkg::CodeBits-1:0], code};
        end
        armed_d   = 1'b1;
        gap_cnt_d = '0;
      end else if (pressed_q) begin
        press_len_d = press_len_inc;
      end else if (armed_q) begin
        if (fire) begin
          pattern_d = '0;
          armed_d   = 1'b0;
          gap_cnt_d = '0;
        end else begin
          gap_cnt_d = gap_cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q   <= 1'b0;
      armed_q     <= 1'b0;
      press_len_q <= '0;
      gap_cnt_q   <= '0;
      pattern_q   <= '0;
    end else begin
      pressed_q   <= pressed_d;
      armed_q     <= armed_d;
      press_len_q <= press_len_d;
      gap_cnt_q   <= gap_cnt_d;
      pattern_q   <= pattern_d;
    end
  end

  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && fire |=> !armed_q && (pattern_q == '0) && (gap_cnt_q == '0))
    else $error("pattern not cleared after emission");

  a_press_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && !pressed_q && level_i |=> pressed_q && !armed_q &&
    (press_len_q == bppd_pkg::CntW'(1)))
    else $error("press edge did not start timing");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_q |-> (press_len_q != '0) && !armed_q)
    else $error("press length zero or timeout armed while pressed");

endmodule

[rtl/core/bppd_out.sv]
// ----------------------------------------------------------------------------
// bppd_out
// Result register: holds one tick's finished patterns and sends them out
// one transaction at a time, lowest button first.
// ----------------------------------------------------------------------------
module bppd_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  bppd_pkg::batch_t               batch_i,
  output logic                           can_load_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [bppd_pkg::OutTdataW-1:0] m_axis_tdata_o,  // [1:0] button_index, [9:2] pattern
  output logic                           m_axis_tlast_o
);

  logic [bppd_pkg::NumButtons-1:0]                        pend_q, pend_d;
  logic [bppd_pkg::NumButtons-1:0][bppd_pkg::PatternW-1:0] pat_q;

  logic [bppd_pkg::NumButtons-1:0] sel;
  logic [bppd_pkg::IdxW-1:0]       sel_idx;
  logic [bppd_pkg::PatternW-1:0]   sel_pat;
  logic                            found;
  logic                            pop;
  logic                            last;

  always_comb begin
    sel     = '0;
    sel_idx = '0;
    sel_pat = '0;
    found   = 1'b0;
    for (int b = 0; b < bppd_pkg::NumButtons; b++) begin
      if (pend_q[b] && !found) begin
        found   = 1'b1;
        sel[b]  = 1'b1;
        sel_idx = bppd_pkg::IdxW'(b);
        sel_pat = pat_q[b];
      end
    end
  end

  assign last       = ((pend_q & ~sel) == '0);
  assign pop        = m_axis_tvalid_o && m_axis_tready_i;
  assign can_load_o = (pend_q == '0) || (pop && last);

  assign m_axis_tvalid_o = found;
  assign m_axis_tlast_o  = last;
  assign m_axis_tdata_o  = bppd_pkg::OutTdataW'({sel_pat, sel_idx});

  always_comb begin
    pend_d = pend_q;
    if (pop) begin
      pend_d = pend_q & ~sel;
    end
    if (load_i) begin
      pend_d = batch_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= batch_i.pattern;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (pend_q == '0) || (pop && $onehot(pend_q)))
    else $error("result batch overwritten before drained");

  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !load_i |=> $countones(pend_q) == $countones($past(pend_q)) - 1)
    else $error("pop did not retire exactly one result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(pend_q))
    else $error("pending results changed while stalled");

endmodule

[test/button_press_pattern_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// button_press_pattern_decoder_core_test
// Self-checking bench for the multi-click pattern decoder. Ticks of button
// levels go in over the input stream; a behavioral copy of the per-button
// press/gap logic predicts every finished pattern, and each output
// transaction is compared against the oldest prediction. Directed cases
// cover glitch-only presses, presses during the gap, simultaneous finishes,
// pattern overflow and register extremes; random click sequences with noise
// follow under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module button_press_pattern_decoder_core_test;

  typedef struct {
    logic [bppd_pkg::IdxW-1:0]     button;
    logic [bppd_pkg::PatternW-1:0] pattern;
    logic                          last;
  } finish_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bppd_pkg::CfgAddrW-1:0]  cfg_addr;
  logic [bppd_pkg::CfgDataW-1:0]  cfg_wdata;
  logic                           s_valid;
  logic                           s_ready;
  logic [bppd_pkg::InTdataW-1:0]  s_data;
  logic                           m_valid;
  logic                           m_ready;
  logic [bppd_pkg::OutTdataW-1:0] m_data;
  logic                           m_last;

  // predictor state
  bppd_pkg::cfg_t                  cfg_shadow;
  logic [bppd_pkg::NumButtons-1:0] btn_down;
  logic [bppd_pkg::CntW-1:0]       hold_len    [bppd_pkg::NumButtons];
  logic [bppd_pkg::CntW-1:0]       idle_len    [bppd_pkg::NumButtons];
  logic [bppd_pkg::NumButtons-1:0] gap_running;
  logic [bppd_pkg::PatternW-1:0]   pattern_acc [bppd_pkg::NumButtons];
  finish_t                         finish_q[$];

  // random click generator state
  logic [bppd_pkg::NumButtons-1:0] gen_level;
  int                              run_left [bppd_pkg::NumButtons];

  bit bursts_on;
  int err_cnt;
  int ticks_sent;
  int patterns_seen;
  int multi_ticks;

  button_press_pattern_decoder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("button_press_pattern_decoder_core_test failed");
    $finish;
  end

  function automatic logic [bppd_pkg::CntW-1:0] sat_inc(input logic [bppd_pkg::CntW-1:0] v);
    return (v == bppd_pkg::CntMax) ? v : v + 1'b1;
  endfunction

  function automatic void model_reset();
    cfg_shadow.glitch_ticks      = bppd_pkg::GlitchReset;
    cfg_shadow.short_ticks       = bppd_pkg::ShortReset;
    cfg_shadow.gap_timeout_ticks = bppd_pkg::TimeoutReset;
    btn_down    = '0;
    gap_running = '0;
    for (int b = 0; b < bppd_pkg::NumButtons; b++) begin
      hold_len[b]    = '0;
      idle_len[b]    = '0;
      pattern_acc[b] = '0;
      run_left[b]    = 0;
    end
    gen_level = '0;
  endfunction

  // one tick of button levels -> finished patterns, in button order
  function automatic void model_tick(input logic [bppd_pkg::NumButtons-1:0] levels);
    finish_t                       batch [bppd_pkg::NumButtons];
    int                            n;
    logic [bppd_pkg::CntW-1:0]     dur;
    logic [bppd_pkg::CodeBits-1:0] code;
    n = 0;
    for (int b = 0; b < bppd_pkg::NumButtons; b++) begin
      if (!btn_down[b] && levels[b]) begin
        btn_down[b]    = 1'b1;
        hold_len[b]    = bppd_pkg::CntW'(1);
        gap_running[b] = 1'b0;
        idle_len[b]    = '0;
      end else if (btn_down[b] && !levels[b]) begin
        dur         = hold_len[b];
        btn_down[b] = 1'b0;
        hold_len[b] = '0;
        if (dur > cfg_shadow.glitch_ticks) begin
          code = bppd_pkg::CodeValid |
                 ((dur < cfg_shadow.short_ticks) ? '0 : bppd_pkg::CodeLong);
          pattern_acc[b] = bppd_pkg::PatternW'({pattern_acc[b], code});
        end
        gap_running[b] = 1'b1;
        idle_len[b]    = '0;
      end else if (btn_down[b]) begin
        hold_len[b] = sat_inc(hold_len[b]);
      end else if (gap_running[b]) begin
        idle_len[b] = sat_inc(idle_len[b]);
        if (idle_len[b] >= cfg_shadow.gap_timeout_ticks) begin
          batch[n].button  = bppd_pkg::IdxW'(b);
          batch[n].pattern = pattern_acc[b];
          batch[n].last    = 1'b0;
          n++;
          pattern_acc[b] = '0;
          gap_running[b] = 1'b0;
          idle_len[b]    = '0;
        end
      end
    end
    if (n > 0) batch[n-1].last = 1'b1;
    if (n > 1) multi_ticks++;
    for (int i = 0; i < n; i++) finish_q.push_back(batch[i]);
  endfunction

  // click-like levels: runs of press and release lengths around the
  // current thresholds, with an occasional random tick mixed in
  function automatic logic [bppd_pkg::NumButtons-1:0] random_levels();
    int g;
    int s;
    int t;
    g = int'(cfg_shadow.glitch_ticks);
    s = int'(cfg_shadow.short_ticks);
    t = int'(cfg_shadow.gap_timeout_ticks);
    if ($urandom_range(0, 9) == 0) return bppd_pkg::NumButtons'($urandom_range(0, 7));
    for (int b = 0; b < bppd_pkg::NumButtons; b++) begin
      if (run_left[b] == 0) begin
        gen_level[b] = ~gen_level[b];
        if (gen_level[b])
          run_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, g + 1)
                                                    : $urandom_range(1, s + 3);
        else
          run_left[b] = ($urandom_range(0, 2) == 0) ? $urandom_range(t + 1, t + 5)
                                                    : $urandom_range(1, (t > 1) ? t : 1);
      end
      run_left[b]--;
    end
    return gen_level;
  endfunction

  task automatic send_tick(input logic [bppd_pkg::NumButtons-1:0] levels);
    int gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= bppd_pkg::InTdataW'(levels);
    forever begin
      @(posedge clk);
      if (s_ready) break;
    end
    model_tick(levels);
    ticks_sent++;
  endtask

  // stop sending and wait until every predicted pattern has come out
  task automatic settle();
    @(negedge clk);
    s_valid <= 1'b0;
    while (finish_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bppd_pkg::cfg_reg_e r,
                           input logic [bppd_pkg::CfgDataW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (r)
      bppd_pkg::REG_GLITCH_TICKS: cfg_shadow.glitch_ticks      = v;
      bppd_pkg::REG_SHORT_TICKS:  cfg_shadow.short_ticks       = v;
      bppd_pkg::REG_GAP_TIMEOUT:  cfg_shadow.gap_timeout_ticks = v;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [bppd_pkg::CntW-1:0] g,
                                input logic [bppd_pkg::CntW-1:0] s,
                                input logic [bppd_pkg::CntW-1:0] t);
    write_reg(bppd_pkg::REG_GLITCH_TICKS, g);
    write_reg(bppd_pkg::REG_SHORT_TICKS, s);
    write_reg(bppd_pkg::REG_GAP_TIMEOUT, t);
  endtask

  task automatic send_list(input logic [bppd_pkg::NumButtons-1:0] seq[$]);
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  // glitch-only press still times out with an empty pattern; a press during
  // the gap keeps the pattern and restarts the timing
  task automatic test_basic_clicks();
    set_thresholds(16'd1, 16'd3, 16'd2);
    write_reg(bppd_pkg::REG_UNUSED, 16'hFFFF);
    send_list({3'b001, 3'b000, 3'b000, 3'b000});
    send_list({3'b010, 3'b010, 3'b000, 3'b010, 3'b010, 3'b010, 3'b010,
               3'b000, 3'b000, 3'b000});
    settle();
  endtask

  // all buttons finish on the same tick
  task automatic test_simultaneous_finish();
    send_list({3'b111, 3'b111, 3'b000, 3'b000, 3'b000});
    settle();
  endtask

  task automatic test_pattern_overflow();
    write_reg(bppd_pkg::REG_GLITCH_TICKS, 16'd0);
    repeat (5) send_list({3'b001, 3'b000});
    send_list({3'b000, 3'b000});
    settle();
  endtask

  task automatic test_config_extremes();
    // zero timeout acts as one; zero short limit makes every press long
    write_reg(bppd_pkg::REG_GAP_TIMEOUT, 16'd0);
    write_reg(bppd_pkg::REG_SHORT_TICKS, 16'd0);
    send_list({3'b100, 3'b100, 3'b000, 3'b000});
    settle();
    write_reg(bppd_pkg::REG_SHORT_TICKS, 16'hFFFF);
    write_reg(bppd_pkg::REG_GAP_TIMEOUT, 16'd1);
    send_list({3'b010, 3'b000, 3'b000});
    settle();
    write_reg(bppd_pkg::REG_GLITCH_TICKS, 16'hFFFF);
    send_list({3'b001, 3'b000, 3'b000});
    settle();
  endtask

  task automatic random_phase(input logic [bppd_pkg::CntW-1:0] g,
                              input logic [bppd_pkg::CntW-1:0] s,
                              input logic [bppd_pkg::CntW-1:0] t, input int count,
                              input bit pause_mid);
    set_thresholds(g, s, t);
    for (int i = 0; i < count; i++) begin
      send_tick(random_levels());
      if (pause_mid && i == count / 2) settle();
    end
    settle();
  endtask

  task automatic test_random_traffic();
    random_phase(16'd1, 16'd4, 16'd3, 70, 1'b0);
    random_phase(16'd0, 16'd2, 16'd1, 65, 1'b1);
    random_phase(16'd3, 16'd7, 16'd6, 70, 1'b0);
    bursts_on = 1'b0;
    random_phase(16'd2, 16'd5, 16'd0, 65, 1'b0);
  endtask

  // output side: random stall bursts while enabled
  initial begin
    int stall;
    stall   = 0;
    m_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        m_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    finish_t exp_fin;
    if (rst_n && m_valid && m_ready) begin
      patterns_seen++;
      if (finish_q.size() == 0) begin
        $error("unexpected result transaction: button_index %0d pattern 0x%02h",
               m_data[bppd_pkg::IdxW-1:0], m_data[bppd_pkg::IdxW +: bppd_pkg::PatternW]);
        err_cnt++;
      end else begin
        exp_fin = finish_q.pop_front();
        if (m_data[bppd_pkg::IdxW-1:0] !== exp_fin.button) begin
          $error("button_index: expected %0d, got %0d", exp_fin.button,
                 m_data[bppd_pkg::IdxW-1:0]);
          err_cnt++;
        end
        if (m_data[bppd_pkg::IdxW +: bppd_pkg::PatternW] !== exp_fin.pattern) begin
          $error("pattern: expected 0x%02h, got 0x%02h", exp_fin.pattern,
                 m_data[bppd_pkg::IdxW +: bppd_pkg::PatternW]);
          err_cnt++;
        end
        if (m_last !== exp_fin.last) begin
          $error("last: expected %0b, got %0b", exp_fin.last, m_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_valid       = 1'b0;
    s_data        = '0;
    bursts_on     = 1'b1;
    err_cnt       = 0;
    ticks_sent    = 0;
    patterns_seen = 0;
    multi_ticks   = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_clicks();
    test_simultaneous_finish();
    test_pattern_overflow();
    test_config_extremes();
    test_random_traffic();

    $display("Sent %0d ticks, checked %0d finished patterns (%0d ticks finished",
             ticks_sent, patterns_seen, multi_ticks);
    $display("  more than one button) across glitch, short and timeout extremes.");
    if (err_cnt == 0) begin
      $display("button_press_pattern_decoder_core_test passed");
    end else begin
      $display("button_press_pattern_decoder_core_test failed");
    end
    $finish;
  end

endmodule

[button_press_pattern_decoder_core.f]
rtl/core/bppd_pkg.sv
rtl/core/bppd_btn.sv
rtl/core/bppd_out.sv
rtl/core/button_press_pattern_decoder_core.sv
test/button_press_pattern_decoder_core_test.sv
